// ===== rtl/bms_pkg.sv =====
// shared types and constants of the buzzer melody sequencer
package bms_pkg;

	localparam int MAX_NOTES_DEF = 256;

	localparam int TICK_W  = 27;
	localparam int BEAT_W  = 11;
	localparam int FREQ_W  = 16;
	localparam int LEN_W   = 8;
	localparam int SLOT_W  = 8;
	localparam int SONG_W  = 9;
	localparam int MS_W    = 16;
	localparam int PROD_W  = LEN_W + BEAT_W;
	localparam int CNT_W   = 5;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = TICK_W;

	localparam logic [TICK_W-1:0] TICK_HZ_RST = TICK_W'(1000000);
	localparam logic [BEAT_W-1:0] BEAT_MS_RST = BEAT_W'(500);

	localparam logic [CFG_IDX_W-1:0] REG_TICK_HZ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BEAT_MS = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_PLAY  = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_FINISH,
		ST_RESULT
	} state_t;

endpackage

// ===== rtl/buzzer_melody_sequencer_top.sv =====
// buzzer melody sequencer: note table, song sequencer and bit-serial tone divider
//
// input channel (in_valid/in_ready) takes one request item: a 1 ms tick, a note
// write, a play or a stop. every item yields exactly one result item on the
// output channel (out_valid/out_ready) with the state after the request.
// cfg_we writes timer_tick_hz (index 0) or beat_ms (index 1) at once.
// an item that starts a note passes from accept to result through the note
// table read, a load state, the restoring divider that forms tick_hz / pitch
// one quotient bit a cycle (the shift-add duration multiply runs beside it),
// a finish state and the result state. other items go straight from idle to
// the result state. the next item is accepted as soon as the block is back in
// idle, even while the previous result still waits in the output register.
// if the receiver stalls, a finished result waits until the output register
// is free; the input side then holds in_ready low.
// reset (arst_n low) stops any song, silences the tone and loads the default
// tick rate and beat; the note table holds no defined contents until written.
module buzzer_melody_sequencer_top
	import bms_pkg::*;
#(
	parameter int MAX_NOTES = MAX_NOTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [SLOT_W-1:0]    note_index,
	input  logic [FREQ_W-1:0]    note_frequency,
	input  logic [LEN_W-1:0]     note_length,
	input  logic [SONG_W-1:0]    song_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 playing,
	output logic                 tone_on,
	output logic [15:0]          reload_value,
	output logic [15:0]          compare_value,
	output logic [7:0]           current_note,
	output logic                 finished,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int PW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int SW = $clog2(MAX_NOTES + 1);
	localparam int LW = (SW > SONG_W) ? SW : SONG_W;
	localparam int EW = (LW > SLOT_W) ? LW : SLOT_W;

	state_t state_q, state_d;

	logic [TICK_W-1:0] tick_hz_q;
	logic [BEAT_W-1:0] beat_ms_q;

	logic [SW-1:0]   song_q;
	logic [PW-1:0]   pos_q;
	logic [MS_W-1:0] elapsed_q;
	logic [MS_W-1:0] dur_q;
	logic            active_q;
	logic [15:0]     reload_q;
	logic            tone_en_q;
	logic            done_q;

	logic            out_valid_q;
	logic            playing_q;
	logic            tone_on_q;
	logic [15:0]     reload_out_q;
	logic [15:0]     compare_out_q;
	logic [7:0]      note_out_q;
	logic            finished_q;

	// note table, pitch in the upper bits, length in the lower
	logic [FREQ_W+LEN_W-1:0] table_mem [MAX_NOTES];
	logic [FREQ_W+LEN_W-1:0] rd_q;

	// divider and multiplier datapath
	logic [TICK_W-1:0] dq_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] divisor_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [LEN_W-1:0]  mplier_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              accept;
	logic              out_load;
	logic [MS_W-1:0]   elapsed_inc;
	logic [SW-1:0]     next_pos;
	logic [EW-1:0]     slot_ext;
	logic [EW-1:0]     slen_ext;
	logic              slot_ok;
	logic              slen_sat;
	logic [FREQ_W:0]   partial;
	logic              q_bit;
	logic [TICK_W-1:0] q_m1;
	logic              q_over;
	logic [PROD_W:0]   dur_sum;
	logic [16:0]       reload_p1;
	logic [PW+7:0]     pos_wide;
	logic              tick_hit;
	logic              song_end;

	assign accept      = in_valid && in_ready;
	assign elapsed_inc = (elapsed_q != {MS_W{1'b1}}) ? elapsed_q + MS_W'(1) : elapsed_q;
	assign next_pos    = SW'(pos_q) + SW'(1);
	assign slot_ext    = EW'(note_index);
	assign slen_ext    = EW'(song_length);
	assign slot_ok     = slot_ext < EW'(MAX_NOTES);
	assign slen_sat    = slen_ext > EW'(MAX_NOTES);
	assign tick_hit    = active_q && (elapsed_inc >= dur_q);
	assign song_end    = next_pos >= song_q;

	// one restoring division step
	assign partial = {rem_q, dq_q[TICK_W-1]};
	assign q_bit   = partial >= {1'b0, divisor_q};

	assign q_m1    = dq_q - TICK_W'(1);
	assign q_over  = (|dq_q[TICK_W-1:17]) || (dq_q[16] && (|dq_q[15:0]));
	assign dur_sum = {1'b0, acc_q} + (PROD_W+1)'(8);

	assign reload_p1 = {1'b0, reload_q} + 17'd1;
	assign pos_wide  = (PW+8)'(pos_q);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_RESULT;
					case (req_t'(req_type))
						REQ_TICK:  if (tick_hit && !song_end) state_d = ST_READ;
						REQ_PLAY:  if (song_length != '0) state_d = ST_READ;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_DIV;
			ST_DIV:    if (cnt_q == CNT_W'(TICK_W - 1)) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_hz_q <= TICK_HZ_RST;
			beat_ms_q <= BEAT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_HZ: tick_hz_q <= cfg_data;
				REG_BEAT_MS: beat_ms_q <= cfg_data[BEAT_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_q    <= '0;
			pos_q     <= '0;
			elapsed_q <= '0;
			dur_q     <= '0;
			active_q  <= 1'b0;
			reload_q  <= '0;
			tone_en_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
						case (req_t'(req_type))
							REQ_TICK: begin
								if (active_q) begin
									elapsed_q <= elapsed_inc;
									if (tick_hit) begin
										if (song_end) begin
											song_q    <= '0;
											pos_q     <= '0;
											elapsed_q <= '0;
											dur_q     <= '0;
											active_q  <= 1'b0;
											reload_q  <= '0;
											tone_en_q <= 1'b0;
											done_q    <= 1'b1;
										end else begin
											pos_q <= next_pos[PW-1:0];
										end
									end
								end
							end
							REQ_PLAY: begin
								if (song_length != '0) begin
									song_q   <= slen_sat ? SW'(MAX_NOTES) : SW'(slen_ext);
									pos_q    <= '0;
									active_q <= 1'b1;
								end
							end
							REQ_STOP: begin
								song_q    <= '0;
								pos_q     <= '0;
								elapsed_q <= '0;
								dur_q     <= '0;
								active_q  <= 1'b0;
								reload_q  <= '0;
								tone_en_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_LOAD: elapsed_q <= '0;
				ST_FINISH: begin
					dur_q <= dur_sum[MS_W+3:4];
					if (divisor_q == '0 || dq_q == '0) begin
						reload_q  <= '0;
						tone_en_q <= 1'b0;
					end else begin
						reload_q  <= q_over ? 16'hFFFF : q_m1[15:0];
						tone_en_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// note table write and registered read
	always_ff @(posedge clk) begin
		if (accept && req_t'(req_type) == REQ_WRITE && slot_ok) begin
			table_mem[PW'(note_index)] <= {note_frequency, note_length};
		end
		rd_q <= table_mem[pos_q];
	end

	// serial divide tick_hz / pitch and shift-add length * beat
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				dq_q      <= tick_hz_q;
				rem_q     <= '0;
				divisor_q <= rd_q[FREQ_W+LEN_W-1:LEN_W];
				mplier_q  <= rd_q[LEN_W-1:0];
				mcand_q   <= PROD_W'(beat_ms_q);
				acc_q     <= '0;
				cnt_q     <= '0;
			end
			ST_DIV: begin
				rem_q    <= q_bit ? 16'(partial - {1'b0, divisor_q}) : partial[FREQ_W-1:0];
				dq_q     <= {dq_q[TICK_W-2:0], q_bit};
				acc_q    <= mplier_q[0] ? acc_q + mcand_q : acc_q;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[LEN_W-1:1]};
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			playing_q     <= 1'b0;
			tone_on_q     <= 1'b0;
			reload_out_q  <= '0;
			compare_out_q <= '0;
			note_out_q    <= '0;
			finished_q    <= 1'b0;
		end else if (out_load) begin
			out_valid_q   <= 1'b1;
			playing_q     <= active_q;
			tone_on_q     <= tone_en_q;
			reload_out_q  <= tone_en_q ? reload_q : 16'd0;
			compare_out_q <= tone_en_q ? reload_p1[16:1] : 16'd0;
			note_out_q    <= pos_wide[7:0];
			finished_q    <= done_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign playing       = playing_q;
	assign tone_on       = tone_on_q;
	assign reload_value  = reload_out_q;
	assign compare_value = compare_out_q;
	assign current_note  = note_out_q;
	assign finished      = finished_q;

endmodule

// ===== tb/buzzer_melody_sequencer_top_tb.sv =====
// testbench of the buzzer melody sequencer: request items checked against a tone and song predictor
module buzzer_melody_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bms_pkg::*;

	localparam int SONG_MAX = MAX_NOTES_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic        playing;
		logic        tone_on;
		logic [15:0] reload;
		logic [15:0] compare;
		logic [7:0]  note;
		logic        finished;
	} player_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           req_type;
	logic [SLOT_W-1:0]    note_index;
	logic [FREQ_W-1:0]    note_frequency;
	logic [LEN_W-1:0]     note_length;
	logic [SONG_W-1:0]    song_length;
	logic                 out_valid;
	logic                 out_ready;
	logic                 playing;
	logic                 tone_on;
	logic [15:0]          reload_value;
	logic [15:0]          compare_value;
	logic [7:0]           current_note;
	logic                 finished;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// predictor copy of the player
	logic [TICK_W-1:0] tick_rate_hz;
	logic [BEAT_W-1:0] beat_len_ms;
	logic [15:0]       pitch_tbl [0:SONG_MAX-1];
	logic [7:0]        len_tbl [0:SONG_MAX-1];
	int unsigned       song_notes;
	int unsigned       note_pos;
	int unsigned       elapsed_ms;
	int unsigned       note_ms;
	bit                song_active;
	int unsigned       tone_reload;
	bit                tone_en;

	player_status_t status_q[$];
	int             mismatch_count = 0;
	int             requests_sent = 0;
	bit             no_idle = 1'b0;
	bit             hold_request = 1'b0;

	buzzer_melody_sequencer_top DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("[buzzer_melody_sequencer_top] ERROR");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic void halt_song();
		tone_en = 1'b0;
		tone_reload = 0;
		song_notes = 0;
		note_pos = 0;
		elapsed_ms = 0;
		note_ms = 0;
		song_active = 1'b0;
	endfunction

	function automatic void begin_note(int unsigned pos);
		int unsigned q;
		logic [15:0] pitch;
		pitch = pitch_tbl[pos];
		q = (pitch == 16'd0) ? 0 : 32'(tick_rate_hz) / 32'(pitch);
		if (q == 0) begin
			tone_en = 1'b0;
			tone_reload = 0;
		end else begin
			q = q - 1;
			tone_reload = (q > 32'hFFFF) ? 32'hFFFF : q;
			tone_en = 1'b1;
		end
		note_ms = (32'(len_tbl[pos]) * 32'(beat_len_ms) + 8) / 16;
		elapsed_ms = 0;
	endfunction

	function automatic player_status_t predict_player(req_t req, logic [7:0] slot,
			logic [15:0] freq, logic [7:0] nlen, logic [8:0] slen);
		player_status_t r;
		bit done;
		int unsigned nxt;
		done = 1'b0;
		case (req)
			REQ_TICK: begin
				if (song_active) begin
					if (elapsed_ms < 32'hFFFF)
						elapsed_ms++;
					if (elapsed_ms >= note_ms) begin
						nxt = note_pos + 1;
						if (nxt >= song_notes) begin
							halt_song();
							done = 1'b1;
						end else begin
							note_pos = nxt;
							begin_note(nxt);
						end
					end
				end
			end
			REQ_WRITE: begin
				pitch_tbl[slot] = freq;
				len_tbl[slot] = nlen;
			end
			REQ_PLAY: begin
				if (slen != 9'd0) begin
					song_notes = (slen > SONG_MAX) ? SONG_MAX : 32'(slen);
					note_pos = 0;
					song_active = 1'b1;
					begin_note(0);
				end
			end
			default: halt_song();
		endcase
		r.playing = song_active;
		r.tone_on = tone_en;
		r.reload = tone_en ? tone_reload[15:0] : 16'd0;
		r.compare = tone_en ? 16'((tone_reload + 1) / 2) : 16'd0;
		r.note = note_pos[7:0];
		r.finished = done;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		player_status_t want;
		if (out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				$display("%0t unexpected result item expected none got note %0d", $time,
					current_note);
				mismatch_count++;
			end else begin
				want = status_q.pop_front();
				check_field("playing", 16'(want.playing), 16'(playing));
				check_field("tone_on", 16'(want.tone_on), 16'(tone_on));
				check_field("reload_value", want.reload, reload_value);
				check_field("compare_value", want.compare, compare_value);
				check_field("current_note", 16'(want.note), 16'(current_note));
				check_field("finished", 16'(want.finished), 16'(finished));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : result_sink
		int stall;
		int held;
		out_ready = 1'b0;
		stall = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				held = HOLD_OFF_CYCLES;
			end
			if (held > 0) begin
				out_ready = 1'b0;
				held--;
			end else if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				stall = idle_gap();
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_request(req_t req, logic [7:0] slot, logic [15:0] freq,
			logic [7:0] nlen, logic [8:0] slen);
		int gap;
		bit ignored;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = req;
		note_index = slot;
		note_frequency = freq;
		note_length = nlen;
		song_length = slen;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		ignored = (req == REQ_TICK && !song_active) || (req == REQ_PLAY && slen == 9'd0);
		status_q.push_back(predict_player(req, slot, freq, nlen, slen));
		if (!ignored)
			requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, 8'($urandom), 16'($urandom), 8'($urandom), 9'($urandom));
	endtask

	task automatic send_write(logic [7:0] slot, logic [15:0] freq, logic [7:0] nlen);
		send_request(REQ_WRITE, slot, freq, nlen, 9'($urandom));
	endtask

	task automatic send_play(logic [8:0] slen);
		send_request(REQ_PLAY, 8'($urandom), 16'($urandom), 8'($urandom), slen);
	endtask

	task automatic send_stop();
		send_request(REQ_STOP, 8'($urandom), 16'($urandom), 8'($urandom), 9'($urandom));
	endtask

	task automatic run_song_out();
		while (song_active)
			send_tick();
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_TICK_HZ)
			tick_rate_hz = data[TICK_W-1:0];
		else if (idx == REG_BEAT_MS)
			beat_len_ms = data[BEAT_W-1:0];
	endtask

	function automatic logic [15:0] random_pitch();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'd0;
		else if (r < 20)
			return 16'($urandom_range(1, 64));
		else
			return 16'($urandom);
	endfunction

	function automatic logic [7:0] random_note_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 8'($urandom_range(0, 23));
		else if (r < 95)
			return 8'($urandom_range(24, 63));
		else if (r < 98)
			return 8'hFF;
		else
			return 8'($urandom);
	endfunction

	function automatic logic [8:0] random_song_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 9'($urandom_range(1, 8));
		else if (r < 95)
			return 9'($urandom_range(1, SONG_MAX));
		else
			return 9'($urandom_range(SONG_MAX + 1, 511));
	endfunction

	function automatic logic [CFG_DAT_W-1:0] random_tick_rate();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return CFG_DAT_W'(1000);
		else if (r < 20)
			return CFG_DAT_W'(100000000);
		else
			return CFG_DAT_W'($urandom_range(1000, 100000000));
	endfunction

	function automatic logic [CFG_DAT_W-1:0] random_beat();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return CFG_DAT_W'($urandom_range(1, 4));
		else if (r < 95)
			return CFG_DAT_W'($urandom_range(5, 50));
		else
			return CFG_DAT_W'(2000);
	endfunction

	task automatic test_directed_basics();
		send_tick();
		send_stop();
		send_play(9'd0);
		send_request(REQ_WRITE, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF);
		send_write(8'd0, 16'd1, 8'd0);      // reload saturates
		send_write(8'd1, 16'd0, 8'd0);      // rest
		send_write(8'd2, 16'hFFFF, 8'd0);
		send_write(8'd3, 16'd2000, 8'd1);   // 31 ms at the reset beat
		send_play(9'd3);
		repeat (3) send_tick();
		send_play(9'd4);
		repeat (5) send_tick();
		send_play(9'd2);                    // restart while playing
		repeat (2) send_tick();
		send_play(9'd4);
		repeat (3) send_tick();
		send_stop();
	endtask

	task automatic test_tone_limits();
		write_register(REG_TICK_HZ, CFG_DAT_W'(1000));
		write_register(REG_BEAT_MS, CFG_DAT_W'(1));
		send_write(8'd0, 16'd1001, 8'd0);   // quotient of zero silences
		send_write(8'd1, 16'd1000, 8'd8);   // reload of zero with tone on
		send_write(8'd2, 16'd1, 8'd23);
		send_write(8'd3, 16'd3, 8'hFF);
		send_play(9'd4);
		run_song_out();
		write_register(REG_TICK_HZ, CFG_DAT_W'(100000000));
		write_register(REG_BEAT_MS, CFG_DAT_W'(2000));
		write_register(REG_UNUSED_2, CFG_DAT_W'($urandom));
		write_register(REG_UNUSED_3, CFG_DAT_W'($urandom));
		send_write(8'd0, 16'd1000, 8'd1);   // 125 ms at the longest beat
		send_play(9'd1);
		run_song_out();
	endtask

	task automatic test_fill_table();
		write_register(REG_TICK_HZ, random_tick_rate());
		write_register(REG_BEAT_MS, CFG_DAT_W'($urandom_range(1, 3)));
		// short notes keep the full song brief
		for (int s = 0; s < SONG_MAX; s++)
			send_write(8'(s), random_pitch(), 8'($urandom_range(0, 23)));
	endtask

	task automatic test_full_song();
		write_register(REG_BEAT_MS, CFG_DAT_W'(1));
		write_register(REG_TICK_HZ, CFG_DAT_W'(1000000));
		no_idle = 1'b1;
		send_play(9'($urandom_range(SONG_MAX + 1, 511)));   // saturates to the table size
		repeat (100) send_tick();
		no_idle = 1'b0;
		run_song_out();
	endtask

	task automatic test_backpressure();
		send_play(9'($urandom_range(2, 20)));
		hold_request = 1'b1;
		no_idle = 1'b1;
		repeat (15) begin
			if ($urandom_range(0, 1))
				send_tick();
			else
				send_write(8'($urandom), random_pitch(), random_note_len());
		end
		no_idle = 1'b0;
		wait_drained();
		send_stop();
	endtask

	task automatic test_random_mix();
		int start;
		int pick;
		start = requests_sent;
		while (requests_sent - start < 40) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				repeat ($urandom_range(1, song_active ? 12 : 3)) send_tick();
			end else if (pick < 63) begin
				send_write(8'($urandom), random_pitch(), random_note_len());
			end else if (pick < 80) begin
				send_play(random_song_len());
			end else if (pick < 86) begin
				send_stop();
			end else if (pick < 89) begin
				send_play(9'd0);
			end else if (pick < 95) begin
				// only finish songs that end soon
				if (beat_len_ms <= 4 && song_notes - note_pos <= 16)
					run_song_out();
				else
					send_stop();
			end else begin
				if ($urandom_range(0, 1))
					write_register(REG_BEAT_MS, random_beat());
				else
					write_register(REG_TICK_HZ, random_tick_rate());
			end
		end
	endtask

	initial begin : stimulus
		in_valid = 1'b0;
		req_type = REQ_TICK;
		note_index = '0;
		note_frequency = '0;
		note_length = '0;
		song_length = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TICK_HZ;
		cfg_data = '0;
		tick_rate_hz = TICK_HZ_RST;
		beat_len_ms = BEAT_MS_RST;
		halt_song();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_basics();
		test_tone_limits();
		test_fill_table();
		test_full_song();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[buzzer_melody_sequencer_top] OK");
		else
			$display("[buzzer_melody_sequencer_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bms_pkg.sv
rtl/buzzer_melody_sequencer_top.sv
tb/buzzer_melody_sequencer_top_tb.sv
